// ===== hdl/rcst_pkg.sv =====
// Shared types and constants for the reference-counted segment table.
// Used by rcst_mem, rcst_ctrl and refcounted_segment_table; depends on nothing.
package rcst_pkg;

    // Request kinds carried in the input tuser bit.
    localparam logic OP_OPEN  = 1'b0;
    localparam logic OP_CLOSE = 1'b1;

    // Result status codes.
    localparam logic [2:0] ST_OPENED     = 3'd0;
    localparam logic [2:0] ST_CREATED    = 3'd1;
    localparam logic [2:0] ST_KEPT       = 3'd2;
    localparam logic [2:0] ST_FREED      = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd4;
    localparam logic [2:0] ST_FULL       = 3'd5;
    localparam logic [2:0] ST_COUNT_FULL = 3'd6;
    localparam logic [2:0] ST_BAD_ID     = 3'd7;

    localparam logic [6:0]  COUNT_MAX = 7'd127;
    localparam logic [31:0] FREE_ID   = 32'd0;

    // One table entry as stored in memory.
    typedef struct packed {
        logic [31:0] seg_id;
        logic [6:0]  count;
    } t_entry;

    // One result item.
    typedef struct packed {
        logic [6:0] ref_count;
        logic [5:0] slot;
        logic [2:0] status;
    } t_result;

endpackage

// ===== hdl/rcst_mem.sv =====
// Slot store of the segment table: one write port, one registered read port.
// Depends on rcst_pkg for the entry type.
module rcst_mem #(
    parameter int SLOTS = 64,
    parameter int AW    = 6
) (
    input  logic                i_clk,
    input  logic                i_wr_en,
    input  logic [AW-1:0]       i_wr_addr,
    input  rcst_pkg::t_entry    i_wr_data,
    input  logic                i_rd_en,
    input  logic [AW-1:0]       i_rd_addr,
    output rcst_pkg::t_entry    o_rd_data
);

    rcst_pkg::t_entry r_mem [SLOTS];
    rcst_pkg::t_entry r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/rcst_ctrl.sv =====
// Sequencer of the segment table: clearing pass, slot scan, decision and write-back.
// Depends on rcst_pkg; drives the ports of rcst_mem.
module rcst_ctrl #(
    parameter int SLOTS = 64,
    parameter int AW    = 6
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    output logic                o_req_ready,
    input  logic                i_req_op,
    input  logic [31:0]         i_req_id,
    output logic                o_mem_wr_en,
    output logic [AW-1:0]       o_mem_wr_addr,
    output rcst_pkg::t_entry    o_mem_wr_data,
    output logic                o_mem_rd_en,
    output logic [AW-1:0]       o_mem_rd_addr,
    input  rcst_pkg::t_entry    i_mem_rd_data,
    output logic                o_res_valid,
    input  logic                i_res_ready,
    output rcst_pkg::t_result   o_res
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_DECIDE = 3'd4;
    localparam logic [2:0] S_RESP   = 3'd5;

    localparam logic [AW-1:0] LAST_ADDR = AW'(SLOTS - 1);

    logic [2:0]        r_state, n_state;
    logic [AW-1:0]     r_addr, n_addr;
    logic              r_rd_pend, n_rd_pend;
    logic [AW-1:0]     r_rd_idx, n_rd_idx;
    logic              r_op, n_op;
    logic [31:0]       r_id, n_id;
    logic              r_hit, n_hit;
    logic [AW-1:0]     r_hit_idx, n_hit_idx;
    logic [6:0]        r_hit_cnt, n_hit_cnt;
    logic              r_free, n_free;
    logic [AW-1:0]     r_free_idx, n_free_idx;
    rcst_pkg::t_result r_res, n_res;

    // Handshake and memory read side.
    assign o_req_ready   = (r_state == S_IDLE);
    assign o_res_valid   = (r_state == S_RESP);
    assign o_res         = r_res;
    assign o_mem_rd_en   = (r_state == S_SCAN);
    assign o_mem_rd_addr = r_addr;

    // Next-state logic: scan bookkeeping, decision and write-back.
    always_comb begin
        n_state    = r_state;
        n_addr     = r_addr;
        n_rd_pend  = 1'b0;
        n_rd_idx   = r_rd_idx;
        n_op       = r_op;
        n_id       = r_id;
        n_hit      = r_hit;
        n_hit_idx  = r_hit_idx;
        n_hit_cnt  = r_hit_cnt;
        n_free     = r_free;
        n_free_idx = r_free_idx;
        n_res      = r_res;

        o_mem_wr_en   = 1'b0;
        o_mem_wr_addr = r_addr;
        o_mem_wr_data = '0;

        // Fold one returning entry into the first-match and first-free results.
        if (r_rd_pend) begin
            if (!r_hit && i_mem_rd_data.seg_id == r_id) begin
                n_hit     = 1'b1;
                n_hit_idx = r_rd_idx;
                n_hit_cnt = i_mem_rd_data.count;
            end
            if (!r_free && i_mem_rd_data.seg_id == rcst_pkg::FREE_ID) begin
                n_free     = 1'b1;
                n_free_idx = r_rd_idx;
            end
        end

        case (r_state)
            S_CLEAR: begin
                o_mem_wr_en   = 1'b1;
                o_mem_wr_addr = r_addr;
                n_addr        = r_addr + AW'(1);
                if (r_addr == LAST_ADDR) begin
                    n_addr  = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    n_op   = i_req_op;
                    n_id   = i_req_id;
                    n_hit  = 1'b0;
                    n_free = 1'b0;
                    n_addr = '0;
                    if (i_req_id == rcst_pkg::FREE_ID) begin
                        n_res.status    = rcst_pkg::ST_BAD_ID;
                        n_res.slot      = '0;
                        n_res.ref_count = '0;
                        n_state         = S_RESP;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                n_rd_pend = 1'b1;
                n_rd_idx  = r_addr;
                n_addr    = r_addr + AW'(1);
                if (r_addr == LAST_ADDR) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_state = S_RESP;
                n_res   = '0;
                if (r_op == rcst_pkg::OP_OPEN) begin
                    if (r_hit) begin
                        n_res.slot = 6'(r_hit_idx);
                        if (r_hit_cnt == rcst_pkg::COUNT_MAX) begin
                            n_res.status    = rcst_pkg::ST_COUNT_FULL;
                            n_res.ref_count = rcst_pkg::COUNT_MAX;
                        end else begin
                            n_res.status         = rcst_pkg::ST_OPENED;
                            n_res.ref_count      = r_hit_cnt + 7'd1;
                            o_mem_wr_en          = 1'b1;
                            o_mem_wr_addr        = r_hit_idx;
                            o_mem_wr_data.seg_id = r_id;
                            o_mem_wr_data.count  = r_hit_cnt + 7'd1;
                        end
                    end else if (r_free) begin
                        n_res.status         = rcst_pkg::ST_CREATED;
                        n_res.slot           = 6'(r_free_idx);
                        n_res.ref_count      = 7'd1;
                        o_mem_wr_en          = 1'b1;
                        o_mem_wr_addr        = r_free_idx;
                        o_mem_wr_data.seg_id = r_id;
                        o_mem_wr_data.count  = 7'd1;
                    end else begin
                        n_res.status = rcst_pkg::ST_FULL;
                    end
                end else begin
                    if (!r_hit) begin
                        n_res.status = rcst_pkg::ST_NOT_FOUND;
                    end else if (r_hit_cnt <= 7'd1) begin
                        // Last reference gone: release the slot.
                        n_res.status  = rcst_pkg::ST_FREED;
                        n_res.slot    = 6'(r_hit_idx);
                        o_mem_wr_en   = 1'b1;
                        o_mem_wr_addr = r_hit_idx;
                    end else begin
                        n_res.status         = rcst_pkg::ST_KEPT;
                        n_res.slot           = 6'(r_hit_idx);
                        n_res.ref_count      = r_hit_cnt - 7'd1;
                        o_mem_wr_en          = 1'b1;
                        o_mem_wr_addr        = r_hit_idx;
                        o_mem_wr_data.seg_id = r_id;
                        o_mem_wr_data.count  = r_hit_cnt - 7'd1;
                    end
                end
            end
            S_RESP: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_addr  = '0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_addr    <= '0;
            r_rd_pend <= 1'b0;
            r_hit     <= 1'b0;
            r_free    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_addr    <= n_addr;
            r_rd_pend <= n_rd_pend;
            r_hit     <= n_hit;
            r_free    <= n_free;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_rd_idx   <= n_rd_idx;
        r_op       <= n_op;
        r_id       <= n_id;
        r_hit_idx  <= n_hit_idx;
        r_hit_cnt  <= n_hit_cnt;
        r_free_idx <= n_free_idx;
        r_res      <= n_res;
    end

    // No write-back may land while the scan is still reading the table.
    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_DRAIN) |-> !o_mem_wr_en)
        else $error("table written during scan");

    // A bad-id result only ever answers a zero segment id.
    a_bad_id_only_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && r_res.status == rcst_pkg::ST_BAD_ID) |-> (r_id == rcst_pkg::FREE_ID))
        else $error("bad id reported for a nonzero id");

    // A created slot always starts with a single reference.
    a_created_count_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && r_res.status == rcst_pkg::ST_CREATED) |-> (r_res.ref_count == 7'd1))
        else $error("created slot with count other than one");

    // Data returning from memory is only ever expected right after a scan read.
    a_read_follows_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |-> ($past(r_state) == S_SCAN))
        else $error("read data expected without a scan read");

endmodule

// ===== hdl/refcounted_segment_table.sv =====
// Top level of the reference-counted segment table: controller, slot memory, result register.
// Depends on rcst_pkg, rcst_mem and rcst_ctrl.
//
// The block keeps TABLE_SLOTS shared-segment slots, each a 32-bit segment id (zero means
// free) and a 7-bit reference count, in a single synchronous memory. After reset the
// block sweeps the memory clear, one slot a cycle, and accepts no request until the sweep
// is done. Each request is one input beat (tuser = opcode, tdata = segment id) and yields
// exactly one output beat. A request with a nonzero id scans every slot through the
// memory's single read port, one slot per cycle, then passes through the drain and decide
// states, writing back at most once, and holds its result until the output register takes
// it. A zero id is answered without a scan. One request is in flight at a time; a
// finished result waits in the output register while the next request is taken.
module refcounted_segment_table #(
    parameter int TABLE_SLOTS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] segment_id
    input  logic        i_s_axis_tuser,   // [0] opcode
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata    // [2:0] status, [8:3] slot, [15:9] ref_count
);

    localparam int AW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

    logic              mem_wr_en;
    logic [AW-1:0]     mem_wr_addr;
    rcst_pkg::t_entry  mem_wr_data;
    logic              mem_rd_en;
    logic [AW-1:0]     mem_rd_addr;
    rcst_pkg::t_entry  mem_rd_data;
    logic              res_valid;
    logic              res_ready;
    rcst_pkg::t_result res;

    logic              r_out_valid;
    rcst_pkg::t_result r_out;

    rcst_ctrl #(
        .SLOTS (TABLE_SLOTS),
        .AW    (AW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_s_axis_tvalid),
        .o_req_ready   (o_s_axis_tready),
        .i_req_op      (i_s_axis_tuser),
        .i_req_id      (i_s_axis_tdata),
        .o_mem_wr_en   (mem_wr_en),
        .o_mem_wr_addr (mem_wr_addr),
        .o_mem_wr_data (mem_wr_data),
        .o_mem_rd_en   (mem_rd_en),
        .o_mem_rd_addr (mem_rd_addr),
        .i_mem_rd_data (mem_rd_data),
        .o_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .o_res         (res)
    );

    rcst_mem #(
        .SLOTS (TABLE_SLOTS),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    // Output register: takes a result when empty or when its beat leaves this cycle.
    assign res_ready = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out;

    // A result beat held back by the sink keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready) |=> (r_out_valid && $stable(r_out)))
        else $error("output beat changed while stalled");

    // A freed slot always reports a count of zero.
    a_freed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == rcst_pkg::ST_FREED) |-> (r_out.ref_count == 7'd0))
        else $error("freed slot with nonzero count");

    // Requests are never taken while a result is being handed to the output register.
    a_no_accept_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> !o_s_axis_tready)
        else $error("request accepted while a result is pending");

endmodule
